// ----- src/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// ssc_pkg
// Word types, widths and helpers shared by the swept circle collision block.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int COORD_W = 32;              // coordinate / velocity width
    localparam int RAD_W   = COORD_W - 1;     // radius width
    localparam int SQ_W    = 2 * COORD_W + 2; // sum of two squares, even
    localparam int ROOT_W  = SQ_W / 2;        // root of a sum of squares
    localparam int DOT_W   = COORD_W + 2;     // projected distance
    localparam int TRV_W   = DOT_W + 1;       // signed travel to contact

    typedef struct packed {
        logic signed [COORD_W-1:0] a_pos_x;
        logic signed [COORD_W-1:0] a_pos_y;
        logic signed [COORD_W-1:0] a_vel_x;
        logic signed [COORD_W-1:0] a_vel_y;
        logic        [RAD_W-1:0]   a_radius;
        logic signed [COORD_W-1:0] b_pos_x;
        logic signed [COORD_W-1:0] b_pos_y;
        logic signed [COORD_W-1:0] b_vel_x;
        logic signed [COORD_W-1:0] b_vel_y;
        logic        [RAD_W-1:0]   b_radius;
        logic                      fix_velocity;
    } t_in_word;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] a_vel_out_x;
        logic signed [COORD_W-1:0] a_vel_out_y;
        logic signed [COORD_W-1:0] b_vel_out_x;
        logic signed [COORD_W-1:0] b_vel_out_y;
    } t_out_word;

    // magnitude of a difference of two coordinates
    function automatic logic [COORD_W-1:0] f_mag_d(input logic [COORD_W:0] x);
        logic [COORD_W:0] t;
        t = x[COORD_W] ? (~x + 1'b1) : x;
        return t[COORD_W-1:0];
    endfunction

    // magnitude of a coordinate; the most negative value maps to 2^(W-1)
    function automatic logic [COORD_W-1:0] f_mag_v(input logic [COORD_W-1:0] x);
        return x[COORD_W-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

// ----- src/ssc_isqrt.sv -----
// ----------------------------------------------------------------------------
// ssc_isqrt
// Pipelined floor square root, one root bit per stage, several lanes that
// share valid and side data.
// ----------------------------------------------------------------------------
module ssc_isqrt #(
    parameter int LANES = 1,
    parameter int IN_W  = 8,
    parameter int TAG_W = 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [TAG_W-1:0]                 i_tag,
    input  logic [LANES-1:0][IN_W-1:0]       i_rad,
    output logic                             o_valid,
    output logic [TAG_W-1:0]                 o_tag,
    output logic [LANES-1:0][IN_W/2-1:0]     o_root
);

    localparam int K     = IN_W / 2;
    localparam int REM_W = K + 2;

    logic [K:0]                      r_valid;
    logic [TAG_W-1:0]                r_tag  [0:K];
    logic [LANES-1:0][IN_W-1:0]      r_rad  [0:K];
    logic [LANES-1:0][REM_W-1:0]     r_rem  [0:K];
    logic [LANES-1:0][K-1:0]         r_root [0:K];
    logic [LANES-1:0][IN_W-1:0]      n_rad  [1:K];
    logic [LANES-1:0][REM_W-1:0]     n_rem  [1:K];
    logic [LANES-1:0][K-1:0]         n_root [1:K];

    always_comb begin
        logic [REM_W-1:0] v_try;
        logic [REM_W-1:0] v_trial;
        for (int s = 1; s <= K; s++) begin
            for (int l = 0; l < LANES; l++) begin
                // bring down the next two radicand bits
                v_try   = {r_rem[s-1][l][K-1:0], r_rad[s-1][l][IN_W-1 -: 2]};
                v_trial = {r_root[s-1][l], 2'b01};
                n_rad[s][l] = r_rad[s-1][l] << 2;
                if (v_try >= v_trial) begin
                    n_rem[s][l]  = v_try - v_trial;
                    n_root[s][l] = {r_root[s-1][l][K-2:0], 1'b1};
                end else begin
                    n_rem[s][l]  = v_try;
                    n_root[s][l] = {r_root[s-1][l][K-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[K-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0]  <= i_tag;
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            for (int s = 1; s <= K; s++) begin
                r_tag[s]  <= r_tag[s-1];
                r_rad[s]  <= n_rad[s];
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
            end
        end
    end

    assign o_valid = r_valid[K];
    assign o_tag   = r_tag[K];
    assign o_root  = r_root[K];

endmodule

// ----- src/ssc_div.sv -----
// ----------------------------------------------------------------------------
// ssc_div
// Pipelined restoring divider, one quotient bit per stage, lanes sharing one
// divisor. A quotient that does not fit QB bits comes out as all ones.
// ----------------------------------------------------------------------------
module ssc_div #(
    parameter int LANES = 1,
    parameter int NUM_W = 16,
    parameter int DEN_W = 8,
    parameter int QB    = 8,
    parameter int TAG_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [TAG_W-1:0]             i_tag,
    input  logic [LANES-1:0][NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]             i_den,
    output logic                         o_valid,
    output logic [TAG_W-1:0]             o_tag,
    output logic [LANES-1:0][QB-1:0]     o_quo
);

    localparam int HI_W  = NUM_W - QB;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [QB:0]                      r_valid;
    logic [TAG_W-1:0]                 r_tag [0:QB];
    logic [DEN_W-1:0]                 r_den [0:QB];
    logic [LANES-1:0]                 r_ovf [0:QB];
    logic [LANES-1:0][DEN_W-1:0]      r_rem [0:QB];
    logic [LANES-1:0][QB-1:0]         r_low [0:QB];
    logic [LANES-1:0][QB-1:0]         r_quo [0:QB];
    logic [LANES-1:0][DEN_W-1:0]      n_rem [1:QB];
    logic [LANES-1:0][QB-1:0]         n_quo [1:QB];
    logic [LANES-1:0][CMP_W-1:0]      w_hi;
    logic [CMP_W-1:0]                 w_den;

    always_comb begin
        w_den = CMP_W'(i_den);
        for (int l = 0; l < LANES; l++) begin
            w_hi[l] = CMP_W'(i_num[l][NUM_W-1:QB]);
        end
    end

    always_comb begin
        logic [DEN_W:0] v_try;
        for (int s = 1; s <= QB; s++) begin
            for (int l = 0; l < LANES; l++) begin
                v_try = {r_rem[s-1][l], r_low[s-1][l][QB-1]};
                if (v_try >= {1'b0, r_den[s-1]}) begin
                    n_rem[s][l] = DEN_W'(v_try - {1'b0, r_den[s-1]});
                    n_quo[s][l] = {r_quo[s-1][l][QB-2:0], 1'b1};
                end else begin
                    n_rem[s][l] = v_try[DEN_W-1:0];
                    n_quo[s][l] = {r_quo[s-1][l][QB-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[QB-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            for (int l = 0; l < LANES; l++) begin
                r_ovf[0][l] <= (w_hi[l] >= w_den);
                r_rem[0][l] <= w_hi[l][DEN_W-1:0];
                r_low[0][l] <= i_num[l][QB-1:0];
            end
            for (int s = 1; s <= QB; s++) begin
                r_tag[s] <= r_tag[s-1];
                r_den[s] <= r_den[s-1];
                r_ovf[s] <= r_ovf[s-1];
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                for (int l = 0; l < LANES; l++) begin
                    r_low[s][l] <= r_low[s-1][l] << 1;
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_ovf[QB][l] ? '1 : r_quo[QB][l];
        end
    end

    assign o_valid = r_valid[QB];
    assign o_tag   = r_tag[QB];

endmodule

// ----- src/swept_circle_collision.sv -----
// ----------------------------------------------------------------------------
// swept_circle_collision
// Swept circle versus circle hit test over one frame, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall carry one t_in_word (two circles and the
//   fix flag). Output channel: o_valid / i_stall carry one t_out_word (hit flag
//   and the velocities, shortened to contact on a hit with fixing on).
//   A word moves at a clock edge with valid high and stall low.
//   Throughput: one word per cycle while the output is not stalled. Each word
//   passes the two root pipelines and the two divider pipelines (one bit per
//   stage each) on its way to the output register.
//   Reset clears every stage valid; the pipeline starts empty.
//   While the receiver stalls a held result, the whole pipeline freezes and
//   o_stall rises; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module swept_circle_collision
    import ssc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    typedef struct packed {
        logic [3:0][COORD_W-1:0] v;   // avx, avy, bvx, bvy
        logic                    fix;
    } t_vel;

    typedef struct packed {
        t_vel                vel;
        logic [COORD_W-1:0]  r;
        logic [SQ_W-1:0]     dsq;
        logic [2*COORD_W:0]  num;
        logic                gt;
        logic                mzero;
    } t_tag_a;

    typedef struct packed {
        t_vel                vel;
        logic [COORD_W-1:0]  r;
        logic [SQ_W-1:0]     dsq;
        logic [ROOT_W-1:0]   speed;
        logic                rej;
    } t_tag_d;

    typedef struct packed {
        t_vel                vel;
        logic [DOT_W-1:0]    dot;
        logic [ROOT_W-1:0]   speed;
        logic                rej;
    } t_tag_t;

    typedef struct packed {
        t_vel                vel;
        logic                hit;
        logic [3:0]          neg;
    } t_tag_s;

    logic w_en;

    // stage 0: input register
    logic     r_s0_valid;
    t_in_word r_s0;
    logic [COORD_W:0]   w_dx, w_dy, w_mx, w_my;
    logic [COORD_W-1:0] w_dxm, w_dym, w_mxm, w_mym;
    t_vel               w_s0_vel;

    // stage 1: squares and dot-product terms
    logic                 r_s1_valid;
    t_vel                 r_s1_vel;
    logic [COORD_W-1:0]   r_s1_r;
    logic [2*COORD_W-1:0] r_s1_dx2, r_s1_dy2, r_s1_mx2, r_s1_my2, r_s1_px, r_s1_py;
    logic                 r_s1_pxn, r_s1_pyn, r_s1_mzero;

    // stage 2: sums
    logic                 r_s2_valid;
    t_vel                 r_s2_vel;
    logic [COORD_W-1:0]   r_s2_r;
    logic [SQ_W-1:0]      r_s2_dsq, r_s2_msq;
    logic [2*COORD_W:0]   r_s2_pos, r_s2_neg;
    logic                 r_s2_mzero;
    logic [2*COORD_W+1:0] w_diff;
    t_tag_a               w_a_in;
    logic [1:0][SQ_W-1:0] w_a_rad;

    logic                   w_a_valid;
    t_tag_a                 w_a_tag;
    logic [1:0][ROOT_W-1:0] w_a_root;
    logic [COORD_W+1:0]     w_reach;
    t_tag_d                 w_d_in;
    logic [0:0][2*COORD_W:0] w_d_num;

    logic                  w_d_valid;
    t_tag_d                w_d_tag;
    logic [0:0][DOT_W-1:0] w_d_quo;

    // stage 4: squares of dot and radius sum
    logic                 r_s4_valid;
    t_vel                 r_s4_vel;
    logic [2*DOT_W-1:0]   r_s4_dot2;
    logic [2*COORD_W-1:0] r_s4_r2;
    logic [DOT_W-1:0]     r_s4_dot;
    logic [ROOT_W-1:0]    r_s4_speed;
    logic [SQ_W-1:0]      r_s4_dsq;
    logic                 r_s4_rej;

    // stage 5: perpendicular distance squared
    logic                 r_s5_valid;
    t_vel                 r_s5_vel;
    logic [SQ_W-1:0]      r_s5_perp2;
    logic [2*COORD_W-1:0] r_s5_r2;
    logic [DOT_W-1:0]     r_s5_dot;
    logic [ROOT_W-1:0]    r_s5_speed;
    logic                 r_s5_rej;
    logic [SQ_W-1:0]      w_perp2;
    t_tag_t               w_t_in;
    logic [0:0][2*COORD_W-1:0] w_t_rad;

    logic                    w_t_valid;
    t_tag_t                  w_t_tag;
    logic [0:0][COORD_W-1:0] w_t_root;

    // stage 6: travel
    logic              r_s6_valid;
    t_vel              r_s6_vel;
    logic [TRV_W-1:0]  r_s6_travel;
    logic [ROOT_W-1:0] r_s6_speed;
    logic              r_s6_rej;
    logic              w_far;
    logic [TRV_W-1:0]  w_tabs;

    // stage 7: hit decision, magnitudes
    logic                    r_s7_valid;
    t_vel                    r_s7_vel;
    logic                    r_s7_hit, r_s7_tneg;
    logic [DOT_W-1:0]        r_s7_tmag;
    logic [3:0][COORD_W-1:0] r_s7_vmag;
    logic [ROOT_W-1:0]       r_s7_speed;

    // stage 8: products for the rescale
    logic                       r_s8_valid;
    t_vel                       r_s8_vel;
    logic                       r_s8_hit;
    logic [3:0]                 r_s8_neg;
    logic [3:0][2*COORD_W+1:0]  r_s8_prod;
    logic [ROOT_W-1:0]          r_s8_speed;
    t_tag_s                     w_s_in;

    logic                    w_s_valid;
    t_tag_s                  w_s_tag;
    logic [3:0][COORD_W-1:0] w_s_quo;
    logic [3:0][COORD_W-1:0] w_vout;

    logic      r_out_valid;
    t_out_word r_out;

    // freeze everything while a result waits on a stalled receiver
    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    // ---------------- stage 0 ----------------
    always_comb begin
        w_dx  = {r_s0.a_pos_x[COORD_W-1], r_s0.a_pos_x} - {r_s0.b_pos_x[COORD_W-1], r_s0.b_pos_x};
        w_dy  = {r_s0.a_pos_y[COORD_W-1], r_s0.a_pos_y} - {r_s0.b_pos_y[COORD_W-1], r_s0.b_pos_y};
        w_mx  = {r_s0.b_vel_x[COORD_W-1], r_s0.b_vel_x} - {r_s0.a_vel_x[COORD_W-1], r_s0.a_vel_x};
        w_my  = {r_s0.b_vel_y[COORD_W-1], r_s0.b_vel_y} - {r_s0.a_vel_y[COORD_W-1], r_s0.a_vel_y};
        w_dxm = f_mag_d(w_dx);
        w_dym = f_mag_d(w_dy);
        w_mxm = f_mag_d(w_mx);
        w_mym = f_mag_d(w_my);
        w_s0_vel.v[0] = r_s0.a_vel_x;
        w_s0_vel.v[1] = r_s0.a_vel_y;
        w_s0_vel.v[2] = r_s0.b_vel_x;
        w_s0_vel.v[3] = r_s0.b_vel_y;
        w_s0_vel.fix  = r_s0.fix_velocity;
    end

    // ---------------- stage 2 ----------------
    always_comb begin
        w_diff       = {1'b0, r_s2_pos} - {1'b0, r_s2_neg};
        w_a_in.vel   = r_s2_vel;
        w_a_in.r     = r_s2_r;
        w_a_in.dsq   = r_s2_dsq;
        w_a_in.num   = w_diff[2*COORD_W:0];
        w_a_in.gt    = !w_diff[2*COORD_W+1] && (w_diff[2*COORD_W:0] != '0);
        w_a_in.mzero = r_s2_mzero;
        w_a_rad[0]   = r_s2_dsq;
        w_a_rad[1]   = r_s2_msq;
    end

    ssc_isqrt #(
        .LANES (2),
        .IN_W  (SQ_W),
        .TAG_W ($bits(t_tag_a))
    ) u_root_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_valid),
        .i_tag   (w_a_in),
        .i_rad   (w_a_rad),
        .o_valid (w_a_valid),
        .o_tag   (w_a_tag),
        .o_root  (w_a_root)
    );

    // early rejects: no motion, too far apart, moving away
    always_comb begin
        w_reach      = {2'b00, w_a_tag.r} + {1'b0, w_a_root[1]};
        w_d_in.vel   = w_a_tag.vel;
        w_d_in.r     = w_a_tag.r;
        w_d_in.dsq   = w_a_tag.dsq;
        w_d_in.speed = w_a_root[1];
        w_d_in.rej   = w_a_tag.mzero || !w_a_tag.gt || ({1'b0, w_a_root[0]} > w_reach);
        w_d_num[0]   = w_a_tag.num;
    end

    ssc_div #(
        .LANES (1),
        .NUM_W (2*COORD_W+1),
        .DEN_W (ROOT_W),
        .QB    (DOT_W),
        .TAG_W ($bits(t_tag_d))
    ) u_div_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_a_valid),
        .i_tag   (w_d_in),
        .i_num   (w_d_num),
        .i_den   (w_a_root[1]),
        .o_valid (w_d_valid),
        .o_tag   (w_d_tag),
        .o_quo   (w_d_quo)
    );

    // ---------------- stage 5 ----------------
    always_comb begin
        if (r_s4_dot2 >= (2*DOT_W)'(r_s4_dsq)) begin
            w_perp2 = '0;
        end else begin
            w_perp2 = r_s4_dsq - r_s4_dot2[SQ_W-1:0];
        end
        w_t_in.vel   = r_s5_vel;
        w_t_in.dot   = r_s5_dot;
        w_t_in.speed = r_s5_speed;
        w_t_in.rej   = r_s5_rej || (r_s5_perp2 >= SQ_W'(r_s5_r2));
        w_t_rad[0]   = r_s5_r2 - r_s5_perp2[2*COORD_W-1:0];
    end

    ssc_isqrt #(
        .LANES (1),
        .IN_W  (2*COORD_W),
        .TAG_W ($bits(t_tag_t))
    ) u_root_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s5_valid),
        .i_tag   (w_t_in),
        .i_rad   (w_t_rad),
        .o_valid (w_t_valid),
        .o_tag   (w_t_tag),
        .o_root  (w_t_root)
    );

    // ---------------- stage 7 ----------------
    always_comb begin
        w_far  = !r_s6_travel[TRV_W-1] && (r_s6_travel != '0)
                 && (TRV_W'(r_s6_speed) < r_s6_travel);
        w_tabs = r_s6_travel[TRV_W-1] ? (~r_s6_travel + 1'b1) : r_s6_travel;
    end

    always_comb begin
        w_s_in.vel = r_s8_vel;
        w_s_in.hit = r_s8_hit;
        w_s_in.neg = r_s8_neg;
    end

    ssc_div #(
        .LANES (4),
        .NUM_W (2*COORD_W+2),
        .DEN_W (ROOT_W),
        .QB    (COORD_W),
        .TAG_W ($bits(t_tag_s))
    ) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s8_valid),
        .i_tag   (w_s_in),
        .i_num   (r_s8_prod),
        .i_den   (r_s8_speed),
        .o_valid (w_s_valid),
        .o_tag   (w_s_tag),
        .o_quo   (w_s_quo)
    );

    // saturate, apply sign, pick scaled or original velocity
    always_comb begin
        logic [COORD_W-1:0] v_lim;
        logic [COORD_W-1:0] v_m;
        for (int l = 0; l < 4; l++) begin
            v_lim = w_s_tag.neg[l] ? {1'b1, {(COORD_W-1){1'b0}}}
                                   : {1'b0, {(COORD_W-1){1'b1}}};
            v_m   = (w_s_quo[l] > v_lim) ? v_lim : w_s_quo[l];
            if (w_s_tag.hit && w_s_tag.vel.fix) begin
                w_vout[l] = w_s_tag.neg[l] ? (~v_m + 1'b1) : v_m;
            end else begin
                w_vout[l] = w_s_tag.vel.v[l];
            end
        end
    end

    // ---------------- stage valids ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_s7_valid  <= 1'b0;
            r_s8_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid  <= i_valid;
            r_s1_valid  <= r_s0_valid;
            r_s2_valid  <= r_s1_valid;
            r_s4_valid  <= w_d_valid;
            r_s5_valid  <= r_s4_valid;
            r_s6_valid  <= w_t_valid;
            r_s7_valid  <= r_s6_valid;
            r_s8_valid  <= r_s7_valid;
            r_out_valid <= w_s_valid;
        end
    end

    // ---------------- stage payloads ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= i_word;

            r_s1_vel   <= w_s0_vel;
            r_s1_r     <= {1'b0, r_s0.a_radius} + {1'b0, r_s0.b_radius};
            r_s1_dx2   <= w_dxm * w_dxm;
            r_s1_dy2   <= w_dym * w_dym;
            r_s1_mx2   <= w_mxm * w_mxm;
            r_s1_my2   <= w_mym * w_mym;
            r_s1_px    <= w_mxm * w_dxm;
            r_s1_py    <= w_mym * w_dym;
            r_s1_pxn   <= w_mx[COORD_W] ^ w_dx[COORD_W];
            r_s1_pyn   <= w_my[COORD_W] ^ w_dy[COORD_W];
            r_s1_mzero <= (w_mx == '0) && (w_my == '0);

            r_s2_vel   <= r_s1_vel;
            r_s2_r     <= r_s1_r;
            r_s2_dsq   <= {2'b00, r_s1_dx2} + {2'b00, r_s1_dy2};
            r_s2_msq   <= {2'b00, r_s1_mx2} + {2'b00, r_s1_my2};
            r_s2_pos   <= {1'b0, r_s1_pxn ? '0 : r_s1_px} + {1'b0, r_s1_pyn ? '0 : r_s1_py};
            r_s2_neg   <= {1'b0, r_s1_pxn ? r_s1_px : '0} + {1'b0, r_s1_pyn ? r_s1_py : '0};
            r_s2_mzero <= r_s1_mzero;

            r_s4_vel   <= w_d_tag.vel;
            r_s4_dot2  <= w_d_quo[0] * w_d_quo[0];
            r_s4_r2    <= w_d_tag.r * w_d_tag.r;
            r_s4_dot   <= w_d_quo[0];
            r_s4_speed <= w_d_tag.speed;
            r_s4_dsq   <= w_d_tag.dsq;
            r_s4_rej   <= w_d_tag.rej;

            r_s5_vel   <= r_s4_vel;
            r_s5_perp2 <= w_perp2;
            r_s5_r2    <= r_s4_r2;
            r_s5_dot   <= r_s4_dot;
            r_s5_speed <= r_s4_speed;
            r_s5_rej   <= r_s4_rej;

            r_s6_vel    <= w_t_tag.vel;
            r_s6_travel <= {1'b0, w_t_tag.dot} - TRV_W'(w_t_root[0]);
            r_s6_speed  <= w_t_tag.speed;
            r_s6_rej    <= w_t_tag.rej;

            r_s7_vel   <= r_s6_vel;
            r_s7_hit   <= !r_s6_rej && !w_far;
            r_s7_tneg  <= r_s6_travel[TRV_W-1];
            r_s7_tmag  <= w_tabs[DOT_W-1:0];
            r_s7_speed <= r_s6_speed;
            for (int l = 0; l < 4; l++) begin
                r_s7_vmag[l] <= f_mag_v(r_s6_vel.v[l]);
            end

            r_s8_vel   <= r_s7_vel;
            r_s8_hit   <= r_s7_hit;
            r_s8_speed <= r_s7_speed;
            for (int l = 0; l < 4; l++) begin
                r_s8_prod[l] <= r_s7_vmag[l] * r_s7_tmag;
                r_s8_neg[l]  <= r_s7_vel.v[l][COORD_W-1] ^ r_s7_tneg;
            end

            r_out.hit         <= w_s_tag.hit;
            r_out.a_vel_out_x <= w_vout[0];
            r_out.a_vel_out_y <= w_vout[1];
            r_out.b_vel_out_x <= w_vout[2];
            r_out.b_vel_out_y <= w_vout[3];
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_s0_valid) && $stable(r_s8_valid) && $stable(r_out_valid)))
        else $error("pipeline moved while frozen");

endmodule
